### rtl/ctsa_pkg.sv
// Shared types, codes and field-step helpers for the calendar time-set and alarm unit.
package ctsa_pkg;

	// Edit modes
	localparam logic [4:0] MODE_SHOW      = 5'd0;
	localparam logic [4:0] MODE_YEAR      = 5'd1;
	localparam logic [4:0] MODE_MONTH     = 5'd2;
	localparam logic [4:0] MODE_DATE      = 5'd3;
	localparam logic [4:0] MODE_HOUR      = 5'd4;
	localparam logic [4:0] MODE_MINUTE    = 5'd5;
	localparam logic [4:0] MODE_SECOND    = 5'd6;
	localparam logic [4:0] MODE_WEEKDAY   = 5'd7;
	localparam logic [4:0] MODE_ALM_VIEW  = 5'd19;
	localparam logic [4:0] MODE_ALM_HOUR  = 5'd20;
	localparam logic [4:0] MODE_ALM_MIN   = 5'd21;
	localparam logic [4:0] MODE_ALM_SEC   = 5'd22;
	localparam logic [4:0] MODE_ALM_WKND  = 5'd23;

	// Key codes
	localparam logic [3:0] KEY_YEAR      = 4'd0;
	localparam logic [3:0] KEY_MONTH     = 4'd1;
	localparam logic [3:0] KEY_DATE      = 4'd2;
	localparam logic [3:0] KEY_UP        = 4'd3;
	localparam logic [3:0] KEY_HOUR      = 4'd4;
	localparam logic [3:0] KEY_MINUTE    = 4'd5;
	localparam logic [3:0] KEY_SECOND    = 4'd6;
	localparam logic [3:0] KEY_DOWN      = 4'd7;
	localparam logic [3:0] KEY_WEEKDAY   = 4'd8;
	localparam logic [3:0] KEY_ALM_HOUR  = 4'd9;
	localparam logic [3:0] KEY_ALM_MIN   = 4'd10;
	localparam logic [3:0] KEY_ALM_SEC   = 4'd11;
	localparam logic [3:0] KEY_ALM_WKND  = 4'd12;
	localparam logic [3:0] KEY_ALM_VIEW  = 4'd13;
	localparam logic [3:0] KEY_CANCEL    = 4'd14;
	localparam logic [3:0] KEY_COMMIT    = 4'd15;

	// Active-low LED patterns
	localparam logic [7:0] LED_YEAR    = 8'hfe;
	localparam logic [7:0] LED_MONTH   = 8'hfd;
	localparam logic [7:0] LED_DATE    = 8'hfb;
	localparam logic [7:0] LED_HOUR    = 8'hf7;
	localparam logic [7:0] LED_MINUTE  = 8'hef;
	localparam logic [7:0] LED_SECOND  = 8'hdf;
	localparam logic [7:0] LED_WEEKDAY = 8'hbf;
	localparam logic [7:0] LED_OFF     = 8'hff;

	// Alarm switch-off offset in seconds
	localparam logic [6:0] ALM_OFF_SECS = 7'd10;
	// Last weekday that counts as a working day
	localparam logic [2:0] LAST_WORKDAY = 3'd5;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] date;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} time_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       weekend;
	} alarm_t;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] led;
		logic       buzzer;
		time_t      edit;
		alarm_t     alarm;
	} state_t;

	typedef struct packed {
		logic       func;
		logic [3:0] key;
		time_t      now;
	} item_t;

	localparam state_t STATE_RESET = '{
		mode:   MODE_SHOW,
		led:    LED_OFF,
		buzzer: 1'b0,
		edit:   '{year: 7'd0, month: 4'd1, date: 5'd1, hour: 5'd0,
		          minute: 6'd0, second: 6'd0, weekday: 3'd1},
		alarm:  '{hour: 5'd0, minute: 6'd0, second: 6'd0, weekend: 1'b0}
	};

	// Up-step: past the top wraps to the low end
	function automatic logic [6:0] step_up(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
		logic [7:0] n;
		n = {1'b0, v} + 8'd1;
		return (n > {1'b0, hi}) ? lo : n[6:0];
	endfunction

	// Down-step: at or below the low end wraps to the top
	function automatic logic [6:0] step_down(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
		return (v <= lo) ? hi : v - 7'd1;
	endfunction

	// Modulo increment for values below twice the modulus minus one
	function automatic logic [6:0] wrap_inc(logic [6:0] v, logic [6:0] m);
		logic [7:0] n;
		n = {1'b0, v} + 8'd1;
		return (n >= {1'b0, m}) ? 7'(n - {1'b0, m}) : n[6:0];
	endfunction

	// Days in month; unknown month codes count as 31 days
	function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
		logic [4:0] len;
		unique case (month)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### rtl/ctsa_next.sv
// Next-state logic: key decoding, field stepping, edit reload and alarm check.
module ctsa_next (
	input  ctsa_pkg::state_t st,
	input  ctsa_pkg::item_t  item,
	output ctsa_pkg::state_t nx,
	output logic             commit
);

	logic       up;
	logic [4:0] len;
	logic [6:0] date_dn;
	logic       alm_match;
	logic       kind_ok;

	assign up  = (item.key == ctsa_pkg::KEY_UP);
	assign len = ctsa_pkg::month_len(st.edit.month, st.edit.year);

	// Date down-step, folded back to 1 when beyond the month length
	always_comb begin
		date_dn = ctsa_pkg::step_down({2'b0, st.edit.date}, 7'd1, {2'b0, len});
		if (date_dn > {2'b0, len}) begin
			date_dn = 7'd1;
		end
	end

	// Alarm time match and day-kind agreement
	assign alm_match = (item.now.hour == st.alarm.hour) &&
	                   (item.now.minute == st.alarm.minute) &&
	                   (item.now.second == st.alarm.second);
	assign kind_ok   = (item.now.weekday <= ctsa_pkg::LAST_WORKDAY) ? !st.alarm.weekend
	                                                                 : st.alarm.weekend;

	always_comb begin
		nx     = st;
		commit = 1'b0;
		if (!item.func) begin
			// Key transaction
			unique case (item.key)
				ctsa_pkg::KEY_YEAR: begin
					nx.mode = ctsa_pkg::MODE_YEAR;    nx.led = ctsa_pkg::LED_YEAR;
				end
				ctsa_pkg::KEY_MONTH: begin
					nx.mode = ctsa_pkg::MODE_MONTH;   nx.led = ctsa_pkg::LED_MONTH;
				end
				ctsa_pkg::KEY_DATE: begin
					nx.mode = ctsa_pkg::MODE_DATE;    nx.led = ctsa_pkg::LED_DATE;
				end
				ctsa_pkg::KEY_HOUR: begin
					nx.mode = ctsa_pkg::MODE_HOUR;    nx.led = ctsa_pkg::LED_HOUR;
				end
				ctsa_pkg::KEY_MINUTE: begin
					nx.mode = ctsa_pkg::MODE_MINUTE;  nx.led = ctsa_pkg::LED_MINUTE;
				end
				ctsa_pkg::KEY_SECOND: begin
					nx.mode = ctsa_pkg::MODE_SECOND;  nx.led = ctsa_pkg::LED_SECOND;
				end
				ctsa_pkg::KEY_WEEKDAY: begin
					nx.mode = ctsa_pkg::MODE_WEEKDAY; nx.led = ctsa_pkg::LED_WEEKDAY;
				end
				ctsa_pkg::KEY_ALM_VIEW: begin
					nx.mode = ctsa_pkg::MODE_ALM_VIEW; nx.led = ctsa_pkg::LED_WEEKDAY;
				end
				ctsa_pkg::KEY_ALM_HOUR: nx.mode = ctsa_pkg::MODE_ALM_HOUR;
				ctsa_pkg::KEY_ALM_MIN:  nx.mode = ctsa_pkg::MODE_ALM_MIN;
				ctsa_pkg::KEY_ALM_SEC:  nx.mode = ctsa_pkg::MODE_ALM_SEC;
				ctsa_pkg::KEY_ALM_WKND: nx.mode = ctsa_pkg::MODE_ALM_WKND;
				ctsa_pkg::KEY_CANCEL:   nx.mode = ctsa_pkg::MODE_SHOW;
				ctsa_pkg::KEY_COMMIT: begin
					nx.mode = ctsa_pkg::MODE_SHOW;
					nx.led  = ctsa_pkg::LED_OFF;
					commit  = 1'b1;
				end
				ctsa_pkg::KEY_UP, ctsa_pkg::KEY_DOWN: begin
					// Step the field of the current mode; date mode also steps the weekday
					unique case (st.mode)
						ctsa_pkg::MODE_YEAR: nx.edit.year = up ?
							ctsa_pkg::step_up(st.edit.year, 7'd0, 7'd99) :
							ctsa_pkg::step_down(st.edit.year, 7'd0, 7'd99);
						ctsa_pkg::MODE_MONTH: nx.edit.month = 4'(up ?
							ctsa_pkg::step_up({3'b0, st.edit.month}, 7'd1, 7'd12) :
							ctsa_pkg::step_down({3'b0, st.edit.month}, 7'd1, 7'd12));
						ctsa_pkg::MODE_DATE: begin
							nx.edit.date = 5'(up ?
								ctsa_pkg::step_up({2'b0, st.edit.date}, 7'd1, {2'b0, len}) :
								date_dn);
							nx.edit.weekday = 3'(up ?
								ctsa_pkg::step_up({4'b0, st.edit.weekday}, 7'd1, 7'd7) :
								ctsa_pkg::step_down({4'b0, st.edit.weekday}, 7'd1, 7'd7));
						end
						ctsa_pkg::MODE_HOUR: nx.edit.hour = 5'(up ?
							ctsa_pkg::step_up({2'b0, st.edit.hour}, 7'd0, 7'd23) :
							ctsa_pkg::step_down({2'b0, st.edit.hour}, 7'd0, 7'd23));
						ctsa_pkg::MODE_MINUTE: nx.edit.minute = 6'(up ?
							ctsa_pkg::step_up({1'b0, st.edit.minute}, 7'd0, 7'd59) :
							ctsa_pkg::step_down({1'b0, st.edit.minute}, 7'd0, 7'd59));
						ctsa_pkg::MODE_SECOND: nx.edit.second = 6'(up ?
							ctsa_pkg::step_up({1'b0, st.edit.second}, 7'd0, 7'd59) :
							ctsa_pkg::step_down({1'b0, st.edit.second}, 7'd0, 7'd59));
						ctsa_pkg::MODE_WEEKDAY: nx.edit.weekday = 3'(up ?
							ctsa_pkg::step_up({4'b0, st.edit.weekday}, 7'd1, 7'd7) :
							ctsa_pkg::step_down({4'b0, st.edit.weekday}, 7'd1, 7'd7));
						ctsa_pkg::MODE_ALM_HOUR: nx.alarm.hour = 5'(up ?
							ctsa_pkg::wrap_inc({2'b0, st.alarm.hour}, 7'd24) :
							ctsa_pkg::step_down({2'b0, st.alarm.hour}, 7'd0, 7'd23));
						ctsa_pkg::MODE_ALM_MIN: nx.alarm.minute = 6'(up ?
							ctsa_pkg::wrap_inc({1'b0, st.alarm.minute}, 7'd60) :
							ctsa_pkg::step_down({1'b0, st.alarm.minute}, 7'd0, 7'd59));
						ctsa_pkg::MODE_ALM_SEC: nx.alarm.second = 6'(up ?
							ctsa_pkg::wrap_inc({1'b0, st.alarm.second}, 7'd60) :
							ctsa_pkg::step_down({1'b0, st.alarm.second}, 7'd0, 7'd59));
						ctsa_pkg::MODE_ALM_WKND: nx.alarm.weekend = !st.alarm.weekend;
						default: ;
					endcase
				end
			endcase
		end else begin
			// Clock sample transaction: reload in show mode, then run the alarm
			if (st.mode == ctsa_pkg::MODE_SHOW) begin
				nx.edit = item.now;
			end
			if (alm_match && kind_ok) begin
				nx.buzzer = 1'b1;
			end
			if ({1'b0, item.now.second} == ({1'b0, st.alarm.second} + ctsa_pkg::ALM_OFF_SECS)) begin
				nx.buzzer = 1'b0;
			end
		end
	end

endmodule

### rtl/calendar_time_set_and_alarm_unit.sv
// Top level: input register, next-state logic and result register of the time-set/alarm unit.

// Takes one transaction per clock, either a key press (func = 0) or a live clock
// sample (func = 1), and answers each with exactly one result carrying the edit
// mode, LED pattern, buzzer state, a commit strobe and the edit copy of the
// calendar time. An accepted transaction is held in an input register, the
// next-state logic then updates the mode, edit and alarm registers, and the
// result is visible from the state and result register. Throughput is one
// transaction per cycle while the result side does not stall, limited by the
// single register stage on each side. Backpressure on the result side stalls
// the input register; the input side keeps accepting while the stored result
// waits as long as that register is free.
module calendar_time_set_and_alarm_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [3:0] key_code,
	input  logic [6:0] now_year,
	input  logic [3:0] now_month,
	input  logic [4:0] now_date,
	input  logic [4:0] now_hour,
	input  logic [5:0] now_minute,
	input  logic [5:0] now_second,
	input  logic [2:0] now_weekday,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] cur_mode,
	output logic [7:0] led_pattern,
	output logic       buzzer_on,
	output logic       commit,
	output logic [6:0] set_year,
	output logic [3:0] set_month,
	output logic [4:0] set_date,
	output logic [4:0] set_hour,
	output logic [5:0] set_minute,
	output logic [5:0] set_second,
	output logic [2:0] set_weekday
);

	logic              valid_s1;
	ctsa_pkg::item_t   item_s1;
	ctsa_pkg::state_t  st_q;
	ctsa_pkg::state_t  st_nx;
	logic              commit_nx;
	logic              commit_q;
	logic              out_valid_q;
	logic              advance;

	// Handshake: item moves on when the result slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{func: func, key: key_code,
			             now: '{year: now_year, month: now_month, date: now_date,
			                    hour: now_hour, minute: now_minute, second: now_second,
			                    weekday: now_weekday}};
		end
	end

	ctsa_next u_next (
		.st     (st_q),
		.item   (item_s1),
		.nx     (st_nx),
		.commit (commit_nx)
	);

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ctsa_pkg::STATE_RESET;
			commit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q     <= st_nx;
				commit_q <= commit_nx;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result ports
	assign out_valid   = out_valid_q;
	assign cur_mode    = st_q.mode;
	assign led_pattern = st_q.led;
	assign buzzer_on   = st_q.buzzer;
	assign commit      = commit_q;
	assign set_year    = st_q.edit.year;
	assign set_month   = st_q.edit.month;
	assign set_date    = st_q.edit.date;
	assign set_hour    = st_q.edit.hour;
	assign set_minute  = st_q.edit.minute;
	assign set_second  = st_q.edit.second;
	assign set_weekday = st_q.edit.weekday;

	// A commit always returns to show mode with the LEDs off
	a_commit_show: assert property (@(posedge clk) disable iff (!arst_n)
		commit_q |-> (st_q.mode == ctsa_pkg::MODE_SHOW) && (st_q.led == ctsa_pkg::LED_OFF))
		else $error("commit without show mode and LEDs off");

	// State holds while a result is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(st_q) && $stable(commit_q))
		else $error("state changed under a stalled result");

	// Buzzer only switches on from a clock sample taken into the state register
	a_buzz_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.buzzer) |-> $past(advance && item_s1.func))
		else $error("buzzer switched on without a clock sample");

	// Mode register holds only defined mode codes
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode <= ctsa_pkg::MODE_WEEKDAY) ||
		((st_q.mode >= ctsa_pkg::MODE_ALM_VIEW) && (st_q.mode <= ctsa_pkg::MODE_ALM_WKND)))
		else $error("undefined edit mode");

	// A pending item is never dropped: stage stays full until it moves on
	a_stage_keep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage lost a transaction");

endmodule
